// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the picker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/rrap_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rrap_pkg;

  // Number of backend slots held in the alive mask.
  localparam int MAX_SLOTS = 16;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int COUNT_W   = $clog2(MAX_SLOTS + 1);
  localparam int CFG_W     = 5;

  // Request opcodes.
  localparam logic OP_PICK   = 1'b0;
  localparam logic OP_STATUS = 1'b1;

  // One request beat.
  typedef struct packed {
    logic              opcode;
    logic [SLOT_W-1:0] slot_index;
    logic              alive_value;
  } pick_in_t;

  // One result beat.
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] chosen_slot;
  } pick_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic apply_status;
    logic load_pick;
    logic scan_step;
    logic emit_found;
    logic emit_none;
  } rrap_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_zero;
    logic hit;
    logic last;
  } rrap_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/round_robin_alive_picker.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Round-robin picker over up to 16 backend slots that skips slots marked dead.
// A status beat is applied while busy stays low, so the next beat can follow
// at once. A pick with an empty pool answers (found low) on the cycle after it
// is accepted, also without raising busy. Any other pick raises busy while it
// checks from 1 up to the count in use (backend_count, saturated at 16) slots;
// one slot per cycle is checked, starting at the rotating pointer. Its result
// appears in the first cycle with busy low again. Each result is shown for
// exactly one cycle under result_strobe; the receiver cannot stall it and must
// take the beat in that cycle. backend_count may be written only while busy is
// low and no result is pending.
module round_robin_alive_picker (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wr_en,
  input  wire logic [rrap_pkg::CFG_W-1:0]  cfg_wr_data,
  input  wire logic                        start,
  output logic                             busy,
  input  wire rrap_pkg::pick_in_t          in_item,
  output logic                             result_strobe,
  output rrap_pkg::pick_out_t              result
);
  import rrap_pkg::*;

  rrap_cmd_t  cmd;
  rrap_stat_t stat;

  rrap_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (in_item.opcode),
    .stat   (stat),
    .busy   (busy),
    .cmd    (cmd)
  );

  rrap_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_item       (in_item),
    .cmd           (cmd),
    .stat          (stat),
    .result_strobe (result_strobe),
    .result        (result)
  );

endmodule

`default_nettype wire

// ===== rtl/core/rrap_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rrap_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic               opcode,
  input  wire rrap_pkg::rrap_stat_t stat,
  output logic                    busy,
  output rrap_pkg::rrap_cmd_t     cmd
);
  import rrap_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state == ST_SCAN);

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (opcode == OP_STATUS) begin
            cmd.apply_status = 1'b1;
          end else if (stat.count_zero) begin
            cmd.emit_none = 1'b1;
          end else begin
            cmd.load_pick = 1'b1;
            state_next    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (stat.hit) begin
          cmd.emit_found = 1'b1;
          state_next     = ST_IDLE;
        end else if (stat.last) begin
          cmd.emit_none = 1'b1;
          state_next    = ST_IDLE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `ASSERT_ALWAYS(a_one_cmd, clk, rst,
    $onehot0({cmd.apply_status, cmd.load_pick, cmd.scan_step, cmd.emit_found, cmd.emit_none}),
    "controller issued more than one command")
  `ASSERT_NEXT(a_scan_ends, clk, rst, busy && (cmd.emit_found || cmd.emit_none), !busy,
    "scan did not return to idle after its result")
  `ASSERT_NEXT(a_pick_scans, clk, rst, cmd.load_pick, busy && !cmd.apply_status,
    "loaded pick did not enter the scan")

endmodule

`default_nettype wire

// ===== rtl/core/rrap_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rrap_dp (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [rrap_pkg::CFG_W-1:0]           cfg_wr_data,
  input  wire rrap_pkg::pick_in_t                   in_item,
  input  wire rrap_pkg::rrap_cmd_t                  cmd,
  output rrap_pkg::rrap_stat_t                      stat,
  output logic                                      result_strobe,
  output rrap_pkg::pick_out_t                       result
);
  import rrap_pkg::*;

  logic [CFG_W-1:0]     backend_count;
  logic [COUNT_W-1:0]   eff_count;
  logic [MAX_SLOTS-1:0] alive;
  logic [SLOT_W-1:0]    ptr;
  logic [SLOT_W-1:0]    idx;
  logic [COUNT_W-1:0]   remaining;
  logic [SLOT_W-1:0]    scan_start;
  logic [COUNT_W-1:0]   start_inc;
  logic [COUNT_W-1:0]   idx_inc;
  logic                 status_hit;

  // Count in use, saturated to the number of slots.
  assign eff_count = (backend_count > CFG_W'(MAX_SLOTS)) ? COUNT_W'(MAX_SLOTS)
                                                         : COUNT_W'(backend_count);

  // Start of the scan: a pointer at or beyond a lowered count restarts at slot 0.
  assign scan_start = ({1'b0, ptr} < eff_count) ? ptr : '0;
  assign start_inc  = {1'b0, scan_start} + COUNT_W'(1);
  assign idx_inc    = {1'b0, idx} + COUNT_W'(1);
  assign status_hit = ({1'b0, in_item.slot_index} < eff_count);

  assign stat.count_zero = (eff_count == '0);
  assign stat.hit        = alive[idx];
  assign stat.last       = (remaining == COUNT_W'(1));

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      backend_count <= '0;
    end else if (cfg_wr_en) begin
      backend_count <= cfg_wr_data;
    end
  end

  // Alive mask and rotating pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      alive <= '1;
      ptr   <= '0;
    end else begin
      if (cmd.apply_status && status_hit) begin
        alive[in_item.slot_index] <= in_item.alive_value;
      end
      if (cmd.load_pick) begin
        ptr <= (start_inc >= eff_count) ? '0 : start_inc[SLOT_W-1:0];
      end
    end
  end

  // Scan position and slots left to check.
  always_ff @(posedge clk) begin
    if (cmd.load_pick) begin
      idx       <= scan_start;
      remaining <= eff_count;
    end else if (cmd.scan_step) begin
      idx       <= (idx_inc >= eff_count) ? '0 : idx_inc[SLOT_W-1:0];
      remaining <= remaining - COUNT_W'(1);
    end
  end

  // Result register, shown for one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= cmd.emit_found || cmd.emit_none;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_found) begin
      result.found       <= 1'b1;
      result.chosen_slot <= idx;
    end else if (cmd.emit_none) begin
      result.found       <= 1'b0;
      result.chosen_slot <= '0;
    end
  end

  `ASSERT_ALWAYS(a_found_alive, clk, rst,
    !(result_strobe && result.found) || alive[result.chosen_slot],
    "chosen slot is not alive")
  `ASSERT_ALWAYS(a_step_left, clk, rst,
    !cmd.scan_step || (remaining > COUNT_W'(1)),
    "scan stepped past its last slot")
  `ASSERT_ALWAYS(a_ptr_range, clk, rst,
    !cmd.load_pick || ({1'b0, scan_start} < eff_count),
    "scan start outside the slots in use")

endmodule

`default_nettype wire
